// ===== rtl/lpjd_pkg.sv =====
// Shared types, constants and small helpers for the line position and junction detector.
// No dependencies; used by every file in rtl/.

package lpjd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int NUM_SENSORS         = 5;

   localparam int THR_W       = 10;
   localparam int STABLE_W    = 8;
   localparam int POS_W       = 11;
   localparam int EDGE_W      = 11;
   localparam int PEAK_W      = 10;
   localparam int TOTAL_W     = 13;
   localparam int JUNC_W      = 3;
   localparam int PACK_BITS   = 6;
   localparam int PACK_W      = PACK_BITS * NUM_SENSORS;
   localparam int IDX_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // Quotient bits produced by the shared divider; every quotient is below 1024.
   localparam int QUOT_W      = 10;
   // Edge fraction is scaled by 256 (one sensor pitch in Q.8 is 256).
   localparam int FRAC_SHIFT  = 8;
   localparam int WEIGHT_UNIT = 500;

   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 10'd512;
   localparam logic [THR_W-1:0]    WATER_RESET     = 10'd0;
   localparam logic [STABLE_W-1:0] STABLE_RESET    = 8'd40;
   localparam logic [STABLE_W-1:0] STABLE_MAX      = 8'd255;

   // Crossing at scan index c sits at EDGE_BASE + 256*c + frac; the right scan negates it.
   localparam logic signed [EDGE_W-1:0] EDGE_BASE = -11'sd704;
   localparam logic signed [EDGE_W-1:0] EDGE_NONE = 11'sd512;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD     = 2'd0,
      CSR_WATER_LEVEL   = 2'd1,
      CSR_STABLE_NEEDED = 2'd2
   } csr_index_type;

   typedef enum logic [JUNC_W-1:0] {
      PAT_OTHER  = 3'd0,
      PAT_LEFT   = 3'd1,
      PAT_RIGHT  = 3'd2,
      PAT_TEE    = 3'd3,
      PAT_LOST   = 3'd4,
      PAT_NORMAL = 3'd5
   } pattern_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_EDGE,
      ST_DIV_POS,
      ST_DIV_LEFT,
      ST_DIV_RIGHT,
      ST_OUTPUT
   } state_type;

   // Centroid weight of each sensor in units of WEIGHT_UNIT.
   function automatic logic signed [2:0] weight_units(input logic [IDX_W-1:0] idx);
      logic signed [2:0] w;
      case (idx)
         3'd0:    w = -3'sd2;
         3'd1:    w = -3'sd1;
         3'd3:    w = 3'sd1;
         3'd4:    w = 3'sd2;
         default: w = 3'sd0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/lpjd_div.sv =====
// Shared restoring divider: one quotient bit per cycle, QUOT_W quotient bits per division.
// Depends on lpjd_pkg for QUOT_W.

module lpjd_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output logic                        done,
   output logic [lpjd_pkg::QUOT_W-1:0] quot
);

   localparam int QW    = lpjd_pkg::QUOT_W;
   localparam int SH_W  = DEN_W + QW - 1;
   localparam int REM_W = (NUM_W > SH_W) ? NUM_W : SH_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  dsh_ff, dsh_in;
   logic [QW-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = REM_W'(num);
         dsh_in  = SH_W'(den) << (QW - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(QW);
      end else if (cnt_ff != '0) begin
         if (rem_ff >= REM_W'(dsh_ff)) begin
            rem_in  = rem_ff - REM_W'(dsh_ff);
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/line_position_and_junction_detector.sv =====
// Top level of the line position and junction detector: sequencer, accumulators, edge search.
// Depends on lpjd_pkg and lpjd_div (shared serial divider).
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-----------------------
//   req     | req_sensor_0 .. req_sensor_4           | req_valid / req_ready
//   rsp     | rsp_line_position .. rsp_packed_readings| rsp_valid / rsp_ready
//   csr     | csr_index, csr_data                    | csr_write_enable only
//
// An item goes from acceptance to rsp_valid through 5 accumulate steps, one edge
// search step, then three passes through the one 10-bit serial divider
// (centroid, left edge, right edge). req_ready returns the cycle after the
// result is taken, so a new item is accepted only after the last result is taken.
// Reset is synchronous and active high; it resets the sequencer, register values and history.
// A stalled result holds in the output registers; no new item is taken meanwhile.

module line_position_and_junction_detector #(
   parameter int SAMPLE_BITS = lpjd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write_enable,
   input  logic [lpjd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lpjd_pkg::CSR_DATA_W-1:0]     csr_data,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sensor_0,
   input  logic [SAMPLE_BITS-1:0]              req_sensor_1,
   input  logic [SAMPLE_BITS-1:0]              req_sensor_2,
   input  logic [SAMPLE_BITS-1:0]              req_sensor_3,
   input  logic [SAMPLE_BITS-1:0]              req_sensor_4,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lpjd_pkg::POS_W-1:0]   rsp_line_position,
   output logic signed [lpjd_pkg::EDGE_W-1:0]  rsp_left_edge,
   output logic signed [lpjd_pkg::EDGE_W-1:0]  rsp_right_edge,
   output logic [lpjd_pkg::PEAK_W-1:0]         rsp_peak_level,
   output logic [lpjd_pkg::TOTAL_W-1:0]        rsp_total_level,
   output logic [lpjd_pkg::JUNC_W-1:0]         rsp_junction,
   output logic [lpjd_pkg::PACK_W-1:0]         rsp_packed_readings
);

   localparam int NS    = lpjd_pkg::NUM_SENSORS;
   localparam int IW    = lpjd_pkg::IDX_W;
   localparam int THR_W = lpjd_pkg::THR_W;
   localparam int VW    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
   localparam int SUM_W = VW + 3;
   localparam int S_W   = VW + 3;
   localparam int SA_W  = VW + 2;
   localparam int NUM_W = VW + 11;
   localparam int DEN_W = SUM_W;
   localparam int QW    = lpjd_pkg::QUOT_W;
   localparam int POS_W = lpjd_pkg::POS_W;
   localparam int EW    = lpjd_pkg::EDGE_W;
   localparam int SW    = lpjd_pkg::STABLE_W;

   lpjd_pkg::state_type state_ff, state_in;

   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic [THR_W-1:0] water_ff, water_in;
   logic [SW-1:0]    stable_needed_ff, stable_needed_in;

   logic signed [POS_W-1:0] held_ff, held_in;
   logic [lpjd_pkg::JUNC_W-1:0] last_pat_ff, last_pat_in;
   logic [SW-1:0]    stable_cnt_ff, stable_cnt_in;

   logic [SAMPLE_BITS-1:0] raw_ff [NS];
   logic [VW-1:0]          v_ff [NS];
   logic [IW-1:0]          idx_ff, idx_in;

   logic [VW-1:0]         peak_ff, peak_in;
   logic [SUM_W-1:0]      total_ff, total_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [S_W-1:0] s_ff, s_in;

   logic          lc_found_ff, lc_found_in;
   logic [IW-1:0] lc_idx_ff, lc_idx_in;
   logic [VW-1:0] lc_prev_ff, lc_prev_in, lc_cur_ff, lc_cur_in;
   logic          rc_found_ff, rc_found_in;
   logic [IW-1:0] rc_idx_ff, rc_idx_in;
   logic [VW-1:0] rc_prev_ff, rc_prev_in, rc_cur_ff, rc_cur_in;

   logic [lpjd_pkg::JUNC_W-1:0] junc_ff, junc_in;
   logic signed [EW-1:0]        left_ff, left_in, right_ff, right_in;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [QW-1:0]    div_quot;

   logic                  req_fire;
   logic [VW-1:0]         thr_ext, water_ext, raw_sel, v_cur;
   logic signed [S_W-1:0] v_sx;
   logic [SA_W-1:0]       s_abs;
   logic [VW-1:0]         lprev [NS];
   logic [VW-1:0]         rprev [NS];
   logic [VW-1:0]         rcur  [NS];
   logic [NS-1:0]         hi, lo;
   logic [lpjd_pkg::JUNC_W-1:0] pat;
   logic [SW-1:0]         cnt_next;
   logic signed [POS_W-1:0] q_pos;
   logic signed [EW-1:0]  edge_left, edge_right;

   lpjd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == lpjd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign thr_ext   = VW'(threshold_ff);
   assign water_ext = VW'(water_ff);

   // Corrected reading of the sensor under the accumulate step.
   assign raw_sel = VW'(raw_ff[idx_ff]);
   assign v_cur   = (raw_sel > water_ext) ? (raw_sel - water_ext) : '0;
   assign v_sx    = $signed(S_W'(v_cur));
   assign s_abs   = s_ff[S_W-1] ? SA_W'(-s_ff) : SA_W'(s_ff);

   // Crossing candidates: left scan runs sensor 0 upward, right scan sensor 4 downward.
   always_comb begin
      lprev[0] = '0;
      rprev[0] = '0;
      for (int c = 0; c < NS; c++) begin
         rcur[c] = v_ff[NS-1-c];
      end
      for (int c = 1; c < NS; c++) begin
         lprev[c] = v_ff[c-1];
         rprev[c] = v_ff[NS-c];
      end
   end

   // Raw pattern against threshold, strict compares both ways.
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         hi[i] = VW'(raw_ff[i]) > thr_ext;
         lo[i] = VW'(raw_ff[i]) < thr_ext;
      end
      if (hi[0] && hi[1] && hi[2] && lo[3] && lo[4]) begin
         pat = lpjd_pkg::PAT_LEFT;
      end else if (lo[0] && lo[1] && hi[2] && hi[3] && hi[4]) begin
         pat = lpjd_pkg::PAT_RIGHT;
      end else if (&hi) begin
         pat = lpjd_pkg::PAT_TEE;
      end else if (&lo) begin
         pat = lpjd_pkg::PAT_LOST;
      end else if (hi[1] || hi[2] || hi[3]) begin
         pat = lpjd_pkg::PAT_NORMAL;
      end else begin
         pat = lpjd_pkg::PAT_OTHER;
      end
      if (pat == last_pat_ff) begin
         cnt_next = (stable_cnt_ff == lpjd_pkg::STABLE_MAX) ? stable_cnt_ff
                                                            : stable_cnt_ff + SW'(1);
      end else begin
         cnt_next = '0;
      end
   end

   assign q_pos      = POS_W'(div_quot);
   assign edge_left  = lpjd_pkg::EDGE_BASE + (EW'(lc_idx_ff) << lpjd_pkg::FRAC_SHIFT)
                       + EW'(div_quot);
   assign edge_right = lpjd_pkg::EDGE_BASE + (EW'(rc_idx_ff) << lpjd_pkg::FRAC_SHIFT)
                       + EW'(div_quot);

   // Sequencer: next state, divider start and operand select.
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = NUM_W'(s_abs) * NUM_W'(lpjd_pkg::WEIGHT_UNIT);
      div_den   = (sum_ff == '0) ? DEN_W'(1) : sum_ff;
      unique case (state_ff)
         lpjd_pkg::ST_IDLE: begin
            if (req_fire) state_in = lpjd_pkg::ST_ACCUM;
         end
         lpjd_pkg::ST_ACCUM: begin
            if (idx_ff == IW'(NS - 1)) state_in = lpjd_pkg::ST_EDGE;
         end
         lpjd_pkg::ST_EDGE: begin
            div_start = 1'b1;
            state_in  = lpjd_pkg::ST_DIV_POS;
         end
         lpjd_pkg::ST_DIV_POS: begin
            div_num = NUM_W'(thr_ext - lc_prev_ff) << lpjd_pkg::FRAC_SHIFT;
            div_den = lc_found_ff ? DEN_W'(lc_cur_ff - lc_prev_ff) : DEN_W'(1);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = lpjd_pkg::ST_DIV_LEFT;
            end
         end
         lpjd_pkg::ST_DIV_LEFT: begin
            div_num = NUM_W'(thr_ext - rc_prev_ff) << lpjd_pkg::FRAC_SHIFT;
            div_den = rc_found_ff ? DEN_W'(rc_cur_ff - rc_prev_ff) : DEN_W'(1);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = lpjd_pkg::ST_DIV_RIGHT;
            end
         end
         lpjd_pkg::ST_DIV_RIGHT: begin
            if (div_done) state_in = lpjd_pkg::ST_OUTPUT;
         end
         lpjd_pkg::ST_OUTPUT: begin
            if (rsp_ready) state_in = lpjd_pkg::ST_IDLE;
         end
         default: state_in = lpjd_pkg::ST_IDLE;
      endcase
   end

   // Datapath next values.
   always_comb begin
      threshold_in     = threshold_ff;
      water_in         = water_ff;
      stable_needed_in = stable_needed_ff;
      held_in          = held_ff;
      last_pat_in      = last_pat_ff;
      stable_cnt_in    = stable_cnt_ff;
      idx_in           = idx_ff;
      peak_in          = peak_ff;
      total_in         = total_ff;
      sum_in           = sum_ff;
      s_in             = s_ff;
      lc_found_in      = lc_found_ff;
      lc_idx_in        = lc_idx_ff;
      lc_prev_in       = lc_prev_ff;
      lc_cur_in        = lc_cur_ff;
      rc_found_in      = rc_found_ff;
      rc_idx_in        = rc_idx_ff;
      rc_prev_in       = rc_prev_ff;
      rc_cur_in        = rc_cur_ff;
      junc_in          = junc_ff;
      left_in          = left_ff;
      right_in         = right_ff;

      if (csr_write_enable) begin
         unique case (lpjd_pkg::csr_index_type'(csr_index))
            lpjd_pkg::CSR_THRESHOLD:     threshold_in     = csr_data[THR_W-1:0];
            lpjd_pkg::CSR_WATER_LEVEL:   water_in         = csr_data[THR_W-1:0];
            lpjd_pkg::CSR_STABLE_NEEDED: stable_needed_in = csr_data[SW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         lpjd_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in   = '0;
               peak_in  = '0;
               total_in = '0;
               sum_in   = '0;
               s_in     = '0;
            end
         end
         lpjd_pkg::ST_ACCUM: begin
            idx_in   = idx_ff + IW'(1);
            if (v_cur > peak_ff) peak_in = v_cur;
            total_in = total_ff + SUM_W'(v_cur);
            if (v_cur > thr_ext) begin
               sum_in = sum_ff + SUM_W'(v_cur);
               case (lpjd_pkg::weight_units(idx_ff))
                  3'sd2:   s_in = s_ff + (v_sx <<< 1);
                  3'sd1:   s_in = s_ff + v_sx;
                  -3'sd1:  s_in = s_ff - v_sx;
                  -3'sd2:  s_in = s_ff - (v_sx <<< 1);
                  default: s_in = s_ff;
               endcase
            end
         end
         lpjd_pkg::ST_EDGE: begin
            // Walk high to low so the first crossing in scan order wins.
            lc_found_in = 1'b0;
            rc_found_in = 1'b0;
            for (int c = NS - 1; c >= 0; c--) begin
               if (lprev[c] < thr_ext && v_ff[c] > thr_ext) begin
                  lc_found_in = 1'b1;
                  lc_idx_in   = IW'(c);
                  lc_prev_in  = lprev[c];
                  lc_cur_in   = v_ff[c];
               end
               if (rprev[c] < thr_ext && rcur[c] > thr_ext) begin
                  rc_found_in = 1'b1;
                  rc_idx_in   = IW'(c);
                  rc_prev_in  = rprev[c];
                  rc_cur_in   = rcur[c];
               end
            end
            last_pat_in   = pat;
            stable_cnt_in = cnt_next;
            if (cnt_next >= stable_needed_ff && pat != lpjd_pkg::PAT_OTHER
                && pat != lpjd_pkg::PAT_NORMAL) begin
               junc_in = pat;
            end else begin
               junc_in = lpjd_pkg::PAT_OTHER;
            end
         end
         lpjd_pkg::ST_DIV_POS: begin
            // Hold the last position when no reading is above threshold.
            if (div_done && sum_ff != '0) begin
               held_in = s_ff[S_W-1] ? -q_pos : q_pos;
            end
         end
         lpjd_pkg::ST_DIV_LEFT: begin
            if (div_done) left_in = lc_found_ff ? edge_left : lpjd_pkg::EDGE_NONE;
         end
         lpjd_pkg::ST_DIV_RIGHT: begin
            if (div_done) right_in = rc_found_ff ? -edge_right : -lpjd_pkg::EDGE_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lpjd_pkg::ST_IDLE;
         threshold_ff     <= lpjd_pkg::THRESHOLD_RESET;
         water_ff         <= lpjd_pkg::WATER_RESET;
         stable_needed_ff <= lpjd_pkg::STABLE_RESET;
         held_ff          <= '0;
         last_pat_ff      <= lpjd_pkg::PAT_OTHER;
         stable_cnt_ff    <= '0;
         idx_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         threshold_ff     <= threshold_in;
         water_ff         <= water_in;
         stable_needed_ff <= stable_needed_in;
         held_ff          <= held_in;
         last_pat_ff      <= last_pat_in;
         stable_cnt_ff    <= stable_cnt_in;
         idx_ff           <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         raw_ff[0] <= req_sensor_0;
         raw_ff[1] <= req_sensor_1;
         raw_ff[2] <= req_sensor_2;
         raw_ff[3] <= req_sensor_3;
         raw_ff[4] <= req_sensor_4;
      end
      if (state_ff == lpjd_pkg::ST_ACCUM) v_ff[idx_ff] <= v_cur;
      peak_ff     <= peak_in;
      total_ff    <= total_in;
      sum_ff      <= sum_in;
      s_ff        <= s_in;
      lc_found_ff <= lc_found_in;
      lc_idx_ff   <= lc_idx_in;
      lc_prev_ff  <= lc_prev_in;
      lc_cur_ff   <= lc_cur_in;
      rc_found_ff <= rc_found_in;
      rc_idx_ff   <= rc_idx_in;
      rc_prev_ff  <= rc_prev_in;
      rc_cur_ff   <= rc_cur_in;
      junc_ff     <= junc_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
   end

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         rsp_packed_readings[lpjd_pkg::PACK_W-1-lpjd_pkg::PACK_BITS*i -: lpjd_pkg::PACK_BITS] =
            raw_ff[i][SAMPLE_BITS-1 -: lpjd_pkg::PACK_BITS];
      end
   end

   assign rsp_valid         = (state_ff == lpjd_pkg::ST_OUTPUT);
   assign rsp_line_position = held_ff;
   assign rsp_left_edge     = left_ff;
   assign rsp_right_edge    = right_ff;
   assign rsp_peak_level    = peak_ff[lpjd_pkg::PEAK_W-1:0];
   assign rsp_total_level   = total_ff[lpjd_pkg::TOTAL_W-1:0];
   assign rsp_junction      = junc_ff;

endmodule

// ===== rtl/lpjd_checker.sv =====
// Port-level checks for the line position and junction detector, bound to the top level.
// Depends on lpjd_pkg for field widths.

module lpjd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [lpjd_pkg::POS_W-1:0]  rsp_line_position,
   input logic [lpjd_pkg::JUNC_W-1:0]        rsp_junction
);

   // No result may be pending right after reset.
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: after taking an item the block is busy and has no result yet.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accepting an item");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new item offered while a result is pending");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_line_position) && $stable(rsp_junction)))
      else $error("stalled result changed");

   a_junction_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_junction <= 3'd4))
      else $error("junction code out of range");

endmodule

bind line_position_and_junction_detector lpjd_checker u_lpjd_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for line_position_and_junction_detector.
// Depends on lpjd_pkg and the RTL under rtl/; the predictor is modeled here.
`timescale 1ns / 1ps

module tb;
   import lpjd_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 60;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 600;

   typedef logic [NUM_SENSORS-1:0][SAMPLE_BITS_DEFAULT-1:0] sweep_t;

   typedef struct packed {
      logic signed [POS_W-1:0]  line_position;
      logic signed [EDGE_W-1:0] left_edge;
      logic signed [EDGE_W-1:0] right_edge;
      logic [PEAK_W-1:0]        peak_level;
      logic [TOTAL_W-1:0]       total_level;
      logic [JUNC_W-1:0]        junction;
      logic [PACK_W-1:0]        packed_readings;
   } sweep_result_t;

   typedef struct {
      sweep_t        raw;
      bit            typed;
      sweep_result_t want;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic req_valid;
   logic req_ready;
   logic [SAMPLE_BITS_DEFAULT-1:0] req_sensor_0, req_sensor_1, req_sensor_2;
   logic [SAMPLE_BITS_DEFAULT-1:0] req_sensor_3, req_sensor_4;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_line_position;
   logic signed [EDGE_W-1:0] rsp_left_edge, rsp_right_edge;
   logic [PEAK_W-1:0] rsp_peak_level;
   logic [TOTAL_W-1:0] rsp_total_level;
   logic [JUNC_W-1:0] rsp_junction;
   logic [PACK_W-1:0] rsp_packed_readings;

   // predictor copy of the registers and history
   int          cfg_threshold = THRESHOLD_RESET;
   int          cfg_water     = WATER_RESET;
   int          cfg_needed    = STABLE_RESET;
   int          held_position = 0;
   pattern_type last_pattern  = PAT_OTHER;
   int          stable_count  = 0;

   sweep_result_t pending_results[$];
   sweep_result_t observed;
   sweep_result_t oldest;
   directed_row_t directed_rows[$];

   int  sender_idle_pct = 0;
   int  stall_pct       = 0;
   logic hold_off       = 1'b0;
   int  sweeps_sent     = 0;
   int  results_seen    = 0;
   int  junction_reports = 0;
   int  mismatches      = 0;
   int  settings_used   = 1;

   line_position_and_junction_detector u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sensor_0        (req_sensor_0),
      .req_sensor_1        (req_sensor_1),
      .req_sensor_2        (req_sensor_2),
      .req_sensor_3        (req_sensor_3),
      .req_sensor_4        (req_sensor_4),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_position   (rsp_line_position),
      .rsp_left_edge       (rsp_left_edge),
      .rsp_right_edge      (rsp_right_edge),
      .rsp_peak_level      (rsp_peak_level),
      .rsp_total_level     (rsp_total_level),
      .rsp_junction        (rsp_junction),
      .rsp_packed_readings (rsp_packed_readings)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Q.8 edge crossing over the corrected readings, scanned from either side
   function automatic int edge_crossing(sweep_t corr, int thr, bit from_right);
      int prev;
      int x;
      int c;
      int pos;
      prev = 0;
      for (c = 0; c < NUM_SENSORS; c++) begin
         x = from_right ? int'(corr[NUM_SENSORS-1-c]) : int'(corr[c]);
         if (prev < thr && x > thr) begin
            pos = -192 + 256 * (c - 2) + (256 * (thr - prev)) / (x - prev);
            return from_right ? -pos : pos;
         end
         prev = x;
      end
      return from_right ? -512 : 512;
   endfunction

   // strict compares on the raw readings; a reading equal to threshold is neither
   function automatic pattern_type classify_sweep(sweep_t raw, int thr);
      logic [NUM_SENSORS-1:0] hi;
      logic [NUM_SENSORS-1:0] lo;
      int i;
      for (i = 0; i < NUM_SENSORS; i++) begin
         hi[i] = int'(raw[i]) > thr;
         lo[i] = int'(raw[i]) < thr;
      end
      if (hi[0] && hi[1] && hi[2] && lo[3] && lo[4]) return PAT_LEFT;
      if (lo[0] && lo[1] && hi[2] && hi[3] && hi[4]) return PAT_RIGHT;
      if (&hi) return PAT_TEE;
      if (&lo) return PAT_LOST;
      if (hi[1] || hi[2] || hi[3]) return PAT_NORMAL;
      return PAT_OTHER;
   endfunction

   function automatic sweep_result_t predict_sweep(sweep_t raw);
      sweep_result_t r;
      sweep_t corr;
      pattern_type pat;
      int i;
      int v;
      int wsum;
      int vsum;
      int peak;
      int total;
      int left_pos;
      int right_pos;
      logic [PACK_W-1:0] pack;
      wsum = 0;
      vsum = 0;
      peak = 0;
      total = 0;
      pack = '0;
      for (i = 0; i < NUM_SENSORS; i++) begin
         v = int'(raw[i]) - cfg_water;
         if (v < 0) v = 0;
         corr[i] = v[SAMPLE_BITS_DEFAULT-1:0];
         if (v > peak) peak = v;
         total += v;
         if (v > cfg_threshold) begin
            wsum += v * (i - 2) * WEIGHT_UNIT;
            vsum += v;
         end
         pack = {pack[PACK_W-PACK_BITS-1:0], raw[i][SAMPLE_BITS_DEFAULT-1 -: PACK_BITS]};
      end
      if (vsum > 0) held_position = wsum / vsum;
      left_pos = edge_crossing(corr, cfg_threshold, 1'b0);
      right_pos = edge_crossing(corr, cfg_threshold, 1'b1);

      pat = classify_sweep(raw, cfg_threshold);
      if (pat == last_pattern) begin
         if (stable_count < STABLE_MAX) stable_count++;
      end else begin
         stable_count = 0;
         last_pattern = pat;
      end

      r.line_position = held_position[POS_W-1:0];
      r.left_edge = left_pos[EDGE_W-1:0];
      r.right_edge = right_pos[EDGE_W-1:0];
      r.peak_level = peak[PEAK_W-1:0];
      r.total_level = total[TOTAL_W-1:0];
      r.junction = (stable_count >= cfg_needed && pat >= PAT_LEFT && pat <= PAT_LOST) ?
                   pat : PAT_OTHER;
      r.packed_readings = pack;
      return r;
   endfunction

   function automatic directed_row_t sweep_row(int s0, int s1, int s2, int s3, int s4);
      directed_row_t row;
      row.raw = {s4[9:0], s3[9:0], s2[9:0], s1[9:0], s0[9:0]};
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic directed_row_t known_row(int s0, int s1, int s2, int s3, int s4,
                                               int pos, int le, int re, int peak,
                                               int total, int junc, int pack);
      directed_row_t row;
      row = sweep_row(s0, s1, s2, s3, s4);
      row.typed = 1'b1;
      row.want.line_position = pos[POS_W-1:0];
      row.want.left_edge = le[EDGE_W-1:0];
      row.want.right_edge = re[EDGE_W-1:0];
      row.want.peak_level = peak[PEAK_W-1:0];
      row.want.total_level = total[TOTAL_W-1:0];
      row.want.junction = junc[JUNC_W-1:0];
      row.want.packed_readings = pack[PACK_W-1:0];
      return row;
   endfunction

   function automatic logic [9:0] above_level(int thr);
      if (thr >= 1023) return 10'd1023;
      return 10'($urandom_range(1023, thr + 1));
   endfunction

   function automatic logic [9:0] below_level(int thr);
      if (thr <= 0) return 10'd0;
      return 10'($urandom_range(thr - 1, 0));
   endfunction

   // readings shaped after a sensor pattern, with an occasional broken sensor
   function automatic sweep_t shaped_sweep(pattern_type shape);
      sweep_t raw;
      logic [NUM_SENSORS-1:0] high_mask;
      int i;
      case (shape)
         PAT_LEFT:   high_mask = 5'b00111;
         PAT_RIGHT:  high_mask = 5'b11100;
         PAT_TEE:    high_mask = 5'b11111;
         PAT_LOST:   high_mask = 5'b00000;
         default: begin
            high_mask = 5'($urandom);
            high_mask[$urandom_range(1, 3)] = 1'b1;
         end
      endcase
      for (i = 0; i < NUM_SENSORS; i++) begin
         if (shape == PAT_OTHER) begin
            raw[i] = ($urandom_range(0, 7) == 0) ? 10'(cfg_threshold) : 10'($urandom);
         end else if ($urandom_range(0, 19) == 0) begin
            raw[i] = $urandom_range(0, 1) ? 10'(cfg_threshold) : 10'($urandom);
         end else begin
            raw[i] = high_mask[i] ? above_level(cfg_threshold) : below_level(cfg_threshold);
         end
      end
      return raw;
   endfunction

   // offer one sweep, hold it until taken, then maybe go idle for a while
   task automatic send_sweep(sweep_t raw, bit typed, sweep_result_t want);
      sweep_result_t predicted;
      req_valid <= 1'b1;
      req_sensor_0 <= raw[0];
      req_sensor_1 <= raw[1];
      req_sensor_2 <= raw[2];
      req_sensor_3 <= raw[3];
      req_sensor_4 <= raw[4];
      do @(posedge clock); while (!req_ready);
      predicted = predict_sweep(raw);
      pending_results.push_back(typed ? want : predicted);
      sweeps_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(int thr, int water, int needed);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_data <= thr[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_WATER_LEVEL;
      csr_data <= water[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_STABLE_NEEDED;
      csr_data <= CSR_DATA_W'(needed[STABLE_W-1:0]);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_threshold = thr;
      cfg_water = water;
      cfg_needed = needed;
   endtask

   task automatic hold_receiver(int cycles);
      hold_off <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off <= 1'b0;
   endtask

   // runs of one pattern, most long enough to pass the stability count
   task automatic random_traffic(int n_items);
      pattern_type shape;
      int sent;
      int run_len;
      int k;
      sweep_result_t unused;
      unused = '0;
      sent = 0;
      shape = pattern_type'($urandom_range(PAT_LEFT, PAT_LOST));
      if (cfg_threshold == 1023) shape = PAT_LOST;
      if (cfg_threshold == 0) shape = PAT_TEE;
      run_len = cfg_needed + $urandom_range(1, 6);
      while (sent < n_items) begin
         if (run_len > n_items - sent) run_len = n_items - sent;
         for (k = 0; k < run_len; k++) send_sweep(shaped_sweep(shape), 1'b0, unused);
         sent += run_len;
         shape = pattern_type'($urandom_range(PAT_OTHER, PAT_NORMAL));
         run_len = ($urandom_range(0, 99) < 60) ? cfg_needed + $urandom_range(1, 4) :
                                                  $urandom_range(1, 5);
      end
   endtask

   task automatic run_phase(int thr, int water, int needed, int n_items,
                            int idle, int stall, int hold_cycles);
      wait_drain();
      write_registers(thr, water, needed);
      settings_used++;
      sender_idle_pct = idle;
      stall_pct = stall;
      if (hold_cycles > 0) begin
         fork
            hold_receiver(hold_cycles);
         join_none
      end
      random_traffic(n_items);
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= !reset && !hold_off && ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         observed.line_position = rsp_line_position;
         observed.left_edge = rsp_left_edge;
         observed.right_edge = rsp_right_edge;
         observed.peak_level = rsp_peak_level;
         observed.total_level = rsp_total_level;
         observed.junction = rsp_junction;
         observed.packed_readings = rsp_packed_readings;
         if (observed.junction != PAT_OTHER) junction_reports++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with no sweep outstanding", results_seen);
         end else begin
            oldest = pending_results.pop_front();
            if (observed.line_position != oldest.line_position ||
                observed.left_edge != oldest.left_edge ||
                observed.right_edge != oldest.right_edge ||
                observed.peak_level != oldest.peak_level ||
                observed.total_level != oldest.total_level ||
                observed.junction != oldest.junction ||
                observed.packed_readings != oldest.packed_readings) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d exp pos=%0d le=%0d re=%0d peak=%0d tot=%0d jn=%0d pk=%h",
                           results_seen, oldest.line_position, oldest.left_edge,
                           oldest.right_edge, oldest.peak_level, oldest.total_level,
                           oldest.junction, oldest.packed_readings);
                  $display("           got pos=%0d le=%0d re=%0d peak=%0d tot=%0d jn=%0d pk=%h",
                           observed.line_position, observed.left_edge,
                           observed.right_edge, observed.peak_level, observed.total_level,
                           observed.junction, observed.packed_readings);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sensor_0 = '0;
      req_sensor_1 = '0;
      req_sensor_2 = '0;
      req_sensor_3 = '0;
      req_sensor_4 = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: threshold 512, no water level, 40 repeats
      directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0, 512, -512, 0, 0, 0, 0));
      directed_rows.push_back(known_row(1023, 1023, 1023, 1023, 1023,
                                        0, -576, 576, 1023, 5115, 0, 'h3FFFFFFF));
      directed_rows.push_back(known_row(1023, 0, 0, 0, 0,
                                        -1000, -576, -448, 1023, 1023, 0, 'h3F000000));
      directed_rows.push_back(known_row(0, 0, 0, 0, 1023,
                                        1000, 448, 576, 1023, 1023, 0, 'h3F));
      // readings at and around threshold: at threshold no centroid, position held
      directed_rows.push_back(known_row(512, 512, 512, 512, 512,
                                        1000, 512, -512, 512, 2560, 0, 'h20820820));
      directed_rows.push_back(known_row(513, 513, 513, 513, 513,
                                        0, -449, 449, 513, 2565, 0, 'h20820820));
      directed_rows.push_back(known_row(511, 511, 511, 511, 511,
                                        0, 512, -512, 511, 2555, 0, 'h1F7DF7DF));
      directed_rows.push_back(sweep_row(1023, 1023, 1023, 0, 0));
      directed_rows.push_back(sweep_row(0, 0, 1023, 1023, 1023));
      directed_rows.push_back(sweep_row(0, 0, 800, 0, 0));
      directed_rows.push_back(sweep_row(600, 900, 520, 100, 0));
      directed_rows.push_back(sweep_row(0, 300, 700, 1023, 512));
      directed_rows.push_back(sweep_row('h2AA, 'h155, 'h2AA, 'h155, 'h2AA));
      directed_rows.push_back(sweep_row('h155, 'h2AA, 'h155, 'h2AA, 'h155));
      foreach (directed_rows[i])
         send_sweep(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);
      req_valid <= 1'b0;

      run_phase(512, 0, 3, 200, 0, 0, 0);
      run_phase(0, 0, 0, 100, 51, 0, 0);
      // saturate the repeat counter
      run_phase(1023, 1023, 255, 280, 0, 51, 0);
      run_phase(300, 100, 5, 300, 12, 12, 0);
      // long receiver hold-off while sweeps keep coming
      run_phase(700, 250, 1, 100, 0, 0, HOLD_CYCLES);
      run_phase($urandom_range(0, 1023), $urandom_range(0, 400), $urandom_range(0, 12),
                150, 12, 12, 0);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("sent %0d sweeps under %0d register settings, %0d results checked",
               sweeps_sent, settings_used, results_seen);
      $display("%0d junction reports seen, %0d mismatches", junction_reports, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
